/* hdl/touch_coordinate_conditioner_top_defines.svh */
// Assertion macros shared by the touch coordinate conditioner modules.
`ifndef TOUCH_COORDINATE_CONDITIONER_TOP_DEFINES_SVH
`define TOUCH_COORDINATE_CONDITIONER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge of clk outside reset.
`define TCC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tcc assertion failed");
// Next-cycle implication, checked on every rising edge of clk outside reset.
`define TCC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tcc assertion failed");
`else
`define TCC_ASSERT_IMP(lbl, ante, cons)
`define TCC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* hdl/tcc_pkg.sv */
// Shared types, constants and codes of the touch coordinate conditioner.
`default_nettype none
package tcc_pkg;

	localparam int RAW_W           = 12;   // raw sample and register width
	localparam int POS_W           = 11;   // screen coordinate width
	localparam int SUM_W           = RAW_W + 2;
	localparam int CFG_IDX_W       = 3;
	localparam int SAMPLE_BITS_DEF = 12;

	// Divide by three as multiply by ceil(2^17 / 3) and shift
	localparam int RECIP_W  = 17;
	localparam int RECIP_SH = 17;
	localparam logic [RECIP_W-1:0] RECIP3 = 17'd43691;

	// Quotient of one axis never exceeds the screen size, so RAW_W steps do
	localparam int DIV_STEPS = RAW_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam logic [RAW_W-1:0] SIZE_MAX = 12'd2048;

	localparam logic [RAW_W-1:0] X_MIN_RST  = 12'd0;
	localparam logic [RAW_W-1:0] X_MAX_RST  = 12'd4095;
	localparam logic [RAW_W-1:0] Y_MIN_RST  = 12'd0;
	localparam logic [RAW_W-1:0] Y_MAX_RST  = 12'd4095;
	localparam logic [RAW_W-1:0] WIDTH_RST  = 12'd480;
	localparam logic [RAW_W-1:0] HEIGHT_RST = 12'd272;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_MIN  = 3'd0,
		REG_X_MAX  = 3'd1,
		REG_Y_MIN  = 3'd2,
		REG_Y_MAX  = 3'd3,
		REG_WIDTH  = 3'd4,
		REG_HEIGHT = 3'd5
	} tcc_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_AVG,
		S_CLAMP,
		S_MUL,
		S_DIV,
		S_FIN,
		S_OUT
	} tcc_state_t;

	typedef struct packed {
		logic [RAW_W-1:0] x_min;
		logic [RAW_W-1:0] x_max;
		logic [RAW_W-1:0] y_min;
		logic [RAW_W-1:0] y_max;
		logic [RAW_W-1:0] width;
		logic [RAW_W-1:0] height;
	} tcc_cfg_t;

	typedef struct packed {
		logic load;      // capture an accepted frame
		logic axis;      // 0 works on X, 1 on Y
		logic avg_en;
		logic clamp_en;
		logic mul_en;
		logic div_en;
		logic fin_en;
		logic out_load;  // move the finished frame to the output register
	} tcc_cmd_t;

	typedef struct packed {
		logic pressed;
	} tcc_stat_t;

endpackage
`default_nettype wire

/* hdl/tcc_regs.sv */
// Calibration and screen-size register file written through the config port.
`default_nettype none
module tcc_regs
	import tcc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [RAW_W-1:0]     wr_data,
	output tcc_cfg_t                  cfg
);

	tcc_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_min  <= X_MIN_RST;
			cfg_q.x_max  <= X_MAX_RST;
			cfg_q.y_min  <= Y_MIN_RST;
			cfg_q.y_max  <= Y_MAX_RST;
			cfg_q.width  <= WIDTH_RST;
			cfg_q.height <= HEIGHT_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_X_MIN:  cfg_q.x_min  <= wr_data;
				REG_X_MAX:  cfg_q.x_max  <= wr_data;
				REG_Y_MIN:  cfg_q.y_min  <= wr_data;
				REG_Y_MAX:  cfg_q.y_max  <= wr_data;
				REG_WIDTH:  cfg_q.width  <= wr_data;
				REG_HEIGHT: cfg_q.height <= wr_data;
				default: ;  // drop writes to unmapped indexes
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

/* hdl/tcc_ctrl.sv */
// Sequencer of the conditioner: steps both axes through average, clamp, scale, divide.
`default_nettype none
`include "touch_coordinate_conditioner_top_defines.svh"
module tcc_ctrl
	import tcc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  wire logic out_stall,
	input  tcc_stat_t stat,
	output tcc_cmd_t  cmd
);

	tcc_state_t       state_q, state_nxt;
	logic             axis_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             accept;
	logic             out_free;

	assign accept   = (state_q == S_IDLE) && in_valid;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE:  if (in_valid) state_nxt = S_AVG;
			S_AVG:   state_nxt = stat.pressed ? S_CLAMP : S_OUT;
			S_CLAMP: state_nxt = S_MUL;
			S_MUL:   state_nxt = S_DIV;
			S_DIV:   if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_nxt = S_FIN;
			S_FIN:   state_nxt = axis_q ? S_OUT : S_AVG;
			S_OUT:   if (out_free) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.axis     = axis_q;
		cmd.load     = accept;
		cmd.avg_en   = (state_q == S_AVG);
		cmd.clamp_en = (state_q == S_CLAMP);
		cmd.mul_en   = (state_q == S_MUL);
		cmd.div_en   = (state_q == S_DIV);
		cmd.fin_en   = (state_q == S_FIN);
		cmd.out_load = (state_q == S_OUT) && out_free;
		in_stall     = (state_q != S_IDLE);
		out_valid    = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				axis_q <= 1'b0;
			end else if (state_q == S_FIN) begin
				axis_q <= 1'b1;
			end
			if (state_q == S_MUL) begin
				cnt_q <= '0;
			end else if (state_q == S_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`TCC_ASSERT_NXT(a_accept_starts_avg, in_valid && !in_stall, state_q == S_AVG)
	`TCC_ASSERT_NXT(a_div_ends, state_q == S_DIV && cnt_q == CNT_W'(DIV_STEPS - 1), state_q == S_FIN)
	`TCC_ASSERT_NXT(a_x_then_y, state_q == S_FIN && !axis_q, state_q == S_AVG && axis_q)

endmodule
`default_nettype wire

/* hdl/tcc_dp.sv */
// Datapath of the conditioner: sums, divide by three, clamp, scale, restoring divider.
`default_nettype none
`include "touch_coordinate_conditioner_top_defines.svh"
module tcc_dp
	import tcc_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  tcc_cmd_t              cmd,
	output tcc_stat_t             stat,
	input  tcc_cfg_t              cfg,
	input  wire logic             pen_down,
	input  wire logic             held_through,
	input  wire logic [RAW_W-1:0] x_first,
	input  wire logic [RAW_W-1:0] x_second,
	input  wire logic [RAW_W-1:0] x_third,
	input  wire logic [RAW_W-1:0] y_first,
	input  wire logic [RAW_W-1:0] y_second,
	input  wire logic [RAW_W-1:0] y_third,
	output logic                  touch_valid,
	output logic [POS_W-1:0]      x_pos,
	output logic [POS_W-1:0]      y_pos,
	output logic                  new_press,
	output logic                  released
);

	localparam int SAMP_W = (SAMPLE_BITS < RAW_W) ? SAMPLE_BITS : RAW_W;
	localparam logic [RAW_W-1:0] SAMP_MASK = RAW_W'((1 << SAMP_W) - 1);
	localparam int MUL_W  = SUM_W + RECIP_W;
	localparam int PROD_W = 2 * RAW_W;

	logic             pressed_q, prev_pressed_q;
	logic [SUM_W-1:0] sum_x_q, sum_y_q;
	logic [RAW_W-1:0] avg_q, num_q, den_q, size_q, rem_q, dvd_q;
	logic             win_empty_q, size_zero_q;
	logic [POS_W-1:0] xres_q, yres_q;
	logic             touch_valid_q, new_press_q, released_q;
	logic [POS_W-1:0] x_pos_q, y_pos_q;

	logic [SUM_W-1:0]  sum_sel;
	logic [MUL_W-1:0]  avg_prod;
	logic [RAW_W-1:0]  lo_sel, hi_sel, size_raw, size_eff, clamp_lo, clamp_v;
	logic [PROD_W-1:0] prod;
	logic [RAW_W:0]    trial;
	logic              ge;
	logic [RAW_W:0]    diff;
	logic [RAW_W-1:0]  mapped, y_val;

	function automatic logic [SUM_W-1:0] sum3(logic [RAW_W-1:0] a, logic [RAW_W-1:0] b,
			logic [RAW_W-1:0] c);
		return SUM_W'(a & SAMP_MASK) + SUM_W'(b & SAMP_MASK) + SUM_W'(c & SAMP_MASK);
	endfunction

	always_comb begin
		sum_sel  = cmd.axis ? sum_y_q : sum_x_q;
		avg_prod = MUL_W'(sum_sel) * MUL_W'(RECIP3);
		lo_sel   = cmd.axis ? cfg.y_min : cfg.x_min;
		hi_sel   = cmd.axis ? cfg.y_max : cfg.x_max;
		size_raw = cmd.axis ? cfg.height : cfg.width;
		size_eff = (size_raw > SIZE_MAX) ? SIZE_MAX : size_raw;
		clamp_lo = (avg_q < lo_sel) ? lo_sel : avg_q;
		clamp_v  = (clamp_lo > hi_sel) ? hi_sel : clamp_lo;
		prod     = PROD_W'(num_q) * PROD_W'(size_q);
		trial    = {rem_q, dvd_q[RAW_W-1]};
		ge       = (trial >= {1'b0, den_q});
		diff     = trial - {1'b0, den_q};
		// dvd_q holds the quotient once the divider has run
		if (win_empty_q || size_zero_q) begin
			mapped = '0;
		end else if (dvd_q >= size_q) begin
			mapped = size_q - 1'b1;
		end else begin
			mapped = dvd_q;
		end
		y_val = size_q - 1'b1 - mapped;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pressed_q <= pen_down & held_through;
			sum_x_q   <= sum3(x_first, x_second, x_third);
			sum_y_q   <= sum3(y_first, y_second, y_third);
			xres_q    <= '0;
			yres_q    <= '0;
		end
		if (cmd.avg_en) begin
			avg_q <= avg_prod[RECIP_SH +: RAW_W];
		end
		if (cmd.clamp_en) begin
			num_q       <= clamp_v - lo_sel;
			den_q       <= hi_sel - lo_sel;
			win_empty_q <= (hi_sel <= lo_sel);
			size_zero_q <= (size_eff == '0);
			size_q      <= size_eff;
		end
		if (cmd.mul_en) begin
			// high half is below den_q since the quotient fits RAW_W bits
			rem_q <= prod[PROD_W-1:RAW_W];
			dvd_q <= prod[RAW_W-1:0];
		end
		if (cmd.div_en) begin
			rem_q <= ge ? diff[RAW_W-1:0] : trial[RAW_W-1:0];
			dvd_q <= {dvd_q[RAW_W-2:0], ge};
		end
		if (cmd.fin_en) begin
			if (cmd.axis) begin
				yres_q <= size_zero_q ? '0 : y_val[POS_W-1:0];
			end else begin
				xres_q <= mapped[POS_W-1:0];
			end
		end
		if (cmd.out_load) begin
			touch_valid_q <= pressed_q;
			x_pos_q       <= xres_q;
			y_pos_q       <= yres_q;
			new_press_q   <= pressed_q & ~prev_pressed_q;
			released_q    <= ~pressed_q & prev_pressed_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pressed_q <= 1'b0;
		end else if (cmd.out_load) begin
			prev_pressed_q <= pressed_q;
		end
	end

	assign stat.pressed = pressed_q;
	assign touch_valid  = touch_valid_q;
	assign x_pos        = x_pos_q;
	assign y_pos        = y_pos_q;
	assign new_press    = new_press_q;
	assign released     = released_q;

	`TCC_ASSERT_IMP(a_rem_below_den, cmd.div_en && !win_empty_q, rem_q < den_q)

endmodule
`default_nettype wire

/* hdl/touch_coordinate_conditioner_top.sv */
// Top level of the touch coordinate conditioner: register file, sequencer and datapath.
`default_nettype none
// One touch scan frame goes in per input beat and exactly one result beat comes out.
// A frame counts as pressed when pen_down and held_through are both set; then each axis
// is averaged over its three samples (truncating divide by three), clamped into the
// calibration window, scaled to the screen size and divided by the window width, with
// Y inverted. A mapped value at or above the screen size saturates to size minus one,
// a zero-width or inverted window maps to 0, a screen size of 0 gives coordinate 0 and
// a size above 2048 acts as 2048. Coordinates read 0 for a frame that is not pressed.
// new_press and released flag the edges against the previous frame's pressed state.
// Sequence: a pressed frame runs from accept through average, clamp, multiply, divide
// and finish steps for X, then for Y, the divide on the one shared restoring divider
// that retires one quotient bit per cycle, and then moves its result into the output
// register, which waits while out_stall holds a previous result; an unpressed frame
// goes from average straight to that move. The next frame is accepted once the
// sequencer is back in idle. One frame is in flight at a time: in_stall
// is high from the accept until the result has moved into the output register, which
// lets the next frame be accepted while a result still waits under out_stall.
// Configuration writes (index 0..5: x_raw_min, x_raw_max, y_raw_min, y_raw_max,
// panel width, panel height; other indexes are dropped) are always taken and belong
// to idle periods. SAMPLE_BITS sets how many low bits of each raw sample count.
module touch_coordinate_conditioner_top
	import tcc_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// frame input channel
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 pen_down,
	input  wire logic                 held_through,
	input  wire logic [RAW_W-1:0]     x_first,
	input  wire logic [RAW_W-1:0]     x_second,
	input  wire logic [RAW_W-1:0]     x_third,
	input  wire logic [RAW_W-1:0]     y_first,
	input  wire logic [RAW_W-1:0]     y_second,
	input  wire logic [RAW_W-1:0]     y_third,
	// result output channel
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      touch_valid,
	output logic [POS_W-1:0]          x_pos,
	output logic [POS_W-1:0]          y_pos,
	output logic                      new_press,
	output logic                      released,
	// configuration write channel
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [RAW_W-1:0]     cfg_data
);

	tcc_cfg_t  cfg;
	tcc_cmd_t  cmd;
	tcc_stat_t stat;

	// Always take config beats; software must write them only while the block is idle
	assign cfg_ready = 1'b1;

	tcc_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Sequencer: owns the in/out handshakes and steps the datapath through both axes
	tcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath: holds the frame, the shared divider and the output register
	tcc_dp #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg          (cfg),
		.pen_down     (pen_down),
		.held_through (held_through),
		.x_first      (x_first),
		.x_second     (x_second),
		.x_third      (x_third),
		.y_first      (y_first),
		.y_second     (y_second),
		.y_third      (y_third),
		.touch_valid  (touch_valid),
		.x_pos        (x_pos),
		.y_pos        (y_pos),
		.new_press    (new_press),
		.released     (released)
	);

endmodule
`default_nettype wire

/* bench/touch_coordinate_conditioner_top_tb.sv */
// Self-checking bench for the touch coordinate conditioner: press edges, calibration and scaling.
`default_nettype none
module touch_coordinate_conditioner_top_tb;
	import tcc_pkg::*;

	localparam int SAMPLES_PER_AXIS = 3;
	localparam int HALF_PERIOD      = 2;
	localparam int RESET_CYCLES     = 7;
	localparam int CYCLE_LIMIT      = 400000;
	localparam int LONG_HOLD        = 300;
	localparam int DRAIN_CYCLES     = 40;
	localparam int CORNER_ITEMS     = 40;
	localparam int RANDOM_PHASES    = 8;
	localparam int RANDOM_ITEMS     = 60;
	localparam int FINAL_ITEMS      = 100;

	// Indexes past the register file; the block must drop writes to them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam logic [RAW_W-1:0]     RAW_FULL     = 12'hFFF;

	typedef struct packed {
		logic             pen;
		logic             held;
		logic [RAW_W-1:0] x0, x1, x2;
		logic [RAW_W-1:0] y0, y1, y2;
	} frame_t;

	typedef struct packed {
		logic             touch;
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic             press;
		logic             lift;
	} report_t;

	// typed = 1: the row carries its own expected report; else the predictor decides
	typedef struct packed {
		frame_t  f;
		logic    typed;
		report_t want;
	} script_row_t;

	// Directed frames, all under the reset calibration (480 x 272, full raw window)
	localparam script_row_t SCRIPT [13] = '{
		// idle frame after reset: all zero
		'{'{1'b0, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
			1'b1, '{1'b0, 11'd0, 11'd0, 1'b0, 1'b0}},
		// press at raw zero: left edge, bottom row after Y inversion
		'{'{1'b1, 1'b1, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
			1'b1, '{1'b1, 11'd0, 11'd271, 1'b1, 1'b0}},
		// full scale saturates to size minus one, Y lands on the top row
		'{'{1'b1, 1'b1, RAW_FULL, RAW_FULL, RAW_FULL, RAW_FULL, RAW_FULL, RAW_FULL},
			1'b1, '{1'b1, 11'd479, 11'd0, 1'b0, 1'b0}},
		// contact lost during sampling: release
		'{'{1'b1, 1'b0, RAW_FULL, RAW_FULL, RAW_FULL, RAW_FULL, RAW_FULL, RAW_FULL},
			1'b1, '{1'b0, 11'd0, 11'd0, 1'b0, 1'b1}},
		// held without pen-down is not a press
		'{'{1'b0, 1'b1, RAW_FULL, RAW_FULL, RAW_FULL, RAW_FULL, RAW_FULL, RAW_FULL},
			1'b1, '{1'b0, 11'd0, 11'd0, 1'b0, 1'b0}},
		// alternating bit patterns
		'{'{1'b1, 1'b1, 12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555},
			1'b0, '0},
		'{'{1'b1, 1'b1, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA},
			1'b0, '0},
		// truncating average just under full scale
		'{'{1'b1, 1'b1, RAW_FULL, RAW_FULL, 12'd4094, 12'd4094, RAW_FULL, RAW_FULL},
			1'b0, '0},
		// truncating average down to zero
		'{'{1'b1, 1'b1, 12'd1, 12'd1, 12'd0, 12'd0, 12'd1, 12'd1},
			1'b0, '0},
		'{'{1'b0, 1'b0, RAW_FULL, RAW_FULL, RAW_FULL, RAW_FULL, RAW_FULL, RAW_FULL},
			1'b1, '{1'b0, 11'd0, 11'd0, 1'b0, 1'b1}},
		'{'{1'b1, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
			1'b1, '{1'b0, 11'd0, 11'd0, 1'b0, 1'b0}},
		// mid-scale press
		'{'{1'b1, 1'b1, 12'd2048, 12'd2047, 12'd2049, 12'd1024, 12'd1023, 12'd1025},
			1'b0, '0},
		'{'{1'b0, 1'b1, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
			1'b1, '{1'b0, 11'd0, 11'd0, 1'b0, 1'b1}}
	};

	// Calibration corners: x_min, x_max, y_min, y_max, width, height
	localparam tcc_cfg_t CORNER_SETTINGS [9] = '{
		'{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd2048, 12'd2048},   // largest screen
		'{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd1, 12'd1},         // one-pixel screen
		'{12'd1000, 12'd1000, 12'd2000, 12'd2000, 12'd480, 12'd272}, // zero-width window
		'{12'd3000, 12'd1000, 12'd4095, 12'd0, 12'd640, 12'd480},  // inverted window
		'{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd0},         // screen size zero
		'{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd2049},   // sizes above 2048
		'{12'd4095, 12'd4095, 12'd0, 12'd0, 12'd2048, 12'd1},      // windows at the rails
		'{12'd0, 12'd1, 12'd4094, 12'd4095, 12'd2048, 12'd2048},   // one-step windows
		'{12'd150, 12'd3950, 12'd250, 12'd3850, 12'd800, 12'd480}  // typical panel
	};

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             in_valid     = 1'b0;
	logic             in_stall;
	logic             pen_down     = 1'b0;
	logic             held_through = 1'b0;
	logic [RAW_W-1:0] x_first  = '0, x_second = '0, x_third = '0;
	logic [RAW_W-1:0] y_first  = '0, y_second = '0, y_third = '0;
	logic             out_valid;
	logic             out_stall    = 1'b0;
	logic             touch_valid;
	logic [POS_W-1:0] x_pos;
	logic [POS_W-1:0] y_pos;
	logic             new_press;
	logic             released;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [RAW_W-1:0]     cfg_data  = '0;

	touch_coordinate_conditioner_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pen_down     (pen_down),
		.held_through (held_through),
		.x_first      (x_first),
		.x_second     (x_second),
		.x_third      (x_third),
		.y_first      (y_first),
		.y_second     (y_second),
		.y_third      (y_third),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.touch_valid  (touch_valid),
		.x_pos        (x_pos),
		.y_pos        (y_pos),
		.new_press    (new_press),
		.released     (released),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// Shadow of the block: calibration registers and last frame's pressed state
	tcc_cfg_t cal = '{X_MIN_RST, X_MAX_RST, Y_MIN_RST, Y_MAX_RST, WIDTH_RST, HEIGHT_RST};
	logic     was_pressed = 1'b0;
	report_t  pending_reports [$];

	int          errors          = 0;
	int          frames_sent     = 0;
	int          presses_sent    = 0;
	int          reports_checked = 0;
	int          reg_writes      = 0;
	int          settings_used   = 0;
	int unsigned cycle_count     = 0;

	// Traffic shaping
	logic    src_idle_on  = 1'b1;
	logic    sink_idle_on = 1'b1;
	int      hold_asks    = 0;
	int      hold_done    = 0;
	int      stall_left   = 0;
	int      stroke_left  = 0;
	logic    cur_typed    = 1'b0;
	report_t cur_want     = '0;

	function automatic int unsigned clip_size(logic [RAW_W-1:0] s);
		int unsigned v;
		v = s;
		if (v > SIZE_MAX) v = SIZE_MAX;
		return v;
	endfunction

	// Average three samples, clamp into [lo, hi] and scale to size (size nonzero)
	function automatic int unsigned scale_axis(logic [RAW_W-1:0] a, b, c, lo, hi,
			int unsigned size);
		int unsigned mean, low, high, m;
		mean = a;
		mean = (mean + b + c) / SAMPLES_PER_AXIS;
		low  = lo;
		high = hi;
		if (mean < low) mean = low;
		if (mean > high) mean = high;
		// empty or inverted window
		if (high <= low) return 0;
		m = (mean - low) * size / (high - low);
		if (m >= size) m = size - 1;
		return m;
	endfunction

	function automatic report_t predict_report(frame_t f);
		report_t     r;
		int unsigned w, h;
		r = '0;
		r.touch = f.pen & f.held;
		if (r.touch) begin
			w = clip_size(cal.width);
			h = clip_size(cal.height);
			if (w != 0)
				r.x = POS_W'(scale_axis(f.x0, f.x1, f.x2, cal.x_min, cal.x_max, w));
			// Y counts from the bottom of the screen
			if (h != 0)
				r.y = POS_W'(h - 1 - scale_axis(f.y0, f.y1, f.y2, cal.y_min, cal.y_max, h));
		end
		r.press = r.touch & ~was_pressed;
		r.lift  = ~r.touch & was_pressed;
		return r;
	endfunction

	function automatic void check_field(string what, int unsigned want, int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
		end
	endfunction

	// Three samples of one axis: full random, rail values, or jitter around a
	// point that is either anywhere or near the calibration window
	function automatic void draw_axis(logic [RAW_W-1:0] lo, hi,
			output logic [RAW_W-1:0] a, b, c);
		logic [RAW_W-1:0] smp [SAMPLES_PER_AXIS];
		int mode, mid, v;
		mode = $urandom_range(0, 7);
		if (mode <= 4)
			mid = $urandom_range(0, 4095);
		else
			mid = int'($urandom_range(lo, hi)) + int'($urandom_range(0, 128)) - 64;
		for (int i = 0; i < SAMPLES_PER_AXIS; i++) begin
			if (mode == 0) begin
				smp[i] = RAW_W'($urandom_range(0, 4095));
			end else if (mode == 1) begin
				smp[i] = $urandom_range(0, 1) ? RAW_FULL : '0;
			end else begin
				v = mid + int'($urandom_range(0, 16)) - 8;
				if (v < 0) v = 0;
				if (v > int'(RAW_FULL)) v = RAW_FULL;
				smp[i] = RAW_W'(v);
			end
		end
		a = smp[0];
		b = smp[1];
		c = smp[2];
	endfunction

	// Mostly strokes of pressed frames, separated by frames with random flags
	function automatic frame_t next_frame();
		frame_t f;
		if (stroke_left != 0) begin
			stroke_left--;
			f.pen  = 1'b1;
			f.held = 1'b1;
		end else begin
			f.pen  = 1'($urandom_range(0, 1));
			f.held = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 3) != 0) stroke_left = $urandom_range(1, 12);
		end
		draw_axis(cal.x_min, cal.x_max, f.x0, f.x1, f.x2);
		draw_axis(cal.y_min, cal.y_max, f.y0, f.y1, f.y2);
		return f;
	endfunction

	// Offer one frame beat; hold it until the block takes it. Call at a falling edge.
	task automatic offer_frame(frame_t f, logic typed, report_t want);
		if (src_idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		cur_typed    = typed;
		cur_want     = want;
		in_valid     <= 1'b1;
		pen_down     <= f.pen;
		held_through <= f.held;
		x_first      <= f.x0;
		x_second     <= f.x1;
		x_third      <= f.x2;
		y_first      <= f.y0;
		y_second     <= f.y1;
		y_third      <= f.y2;
		frames_sent++;
		if (f.pen & f.held) presses_sent++;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RAW_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// Stop offering and wait until every expected report has come back
	task automatic drain_reports();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic apply_settings(tcc_cfg_t s);
		drain_reports();
		// bracket the real writes with writes to unused indexes
		write_reg(REG_SPARE_LO, RAW_W'($urandom_range(0, 4095)));
		write_reg(REG_X_MIN, s.x_min);
		write_reg(REG_X_MAX, s.x_max);
		write_reg(REG_Y_MIN, s.y_min);
		write_reg(REG_Y_MAX, s.y_max);
		write_reg(REG_WIDTH, s.width);
		write_reg(REG_HEIGHT, s.height);
		write_reg(REG_SPARE_HI, RAW_W'($urandom_range(0, 4095)));
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Sample every handshake at the rising edge: register writes, result beats, frame beats
	always @(posedge clk) begin : watch_beats
		report_t got, want, model;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				reg_writes++;
				case (cfg_index)
					REG_X_MIN:  cal.x_min  = cfg_data;
					REG_X_MAX:  cal.x_max  = cfg_data;
					REG_Y_MIN:  cal.y_min  = cfg_data;
					REG_Y_MAX:  cal.y_max  = cfg_data;
					REG_WIDTH:  cal.width  = cfg_data;
					REG_HEIGHT: cal.height = cfg_data;
					default: ;
				endcase
			end
			// check results before queueing this edge's frame
			if (out_valid && !out_stall) begin
				got = '{touch_valid, x_pos, y_pos, new_press, released};
				if (pending_reports.size() == 0) begin
					errors++;
					$display("%0t: result beat with no report expected, got %b %0d %0d %b %b",
						$time, got.touch, got.x, got.y, got.press, got.lift);
				end else begin
					want = pending_reports.pop_front();
					reports_checked++;
					check_field("touch_valid", want.touch, got.touch);
					check_field("x_pos", want.x, got.x);
					check_field("y_pos", want.y, got.y);
					check_field("new_press", want.press, got.press);
					check_field("released", want.lift, got.lift);
				end
			end
			if (in_valid && !in_stall) begin
				model = predict_report('{pen_down, held_through, x_first, x_second, x_third,
					y_first, y_second, y_third});
				was_pressed = model.touch;
				pending_reports.push_back(cur_typed ? cur_want : model);
			end
		end
	end

	// Result side: random stall bursts, plus a long hold-off whenever one is asked for
	always @(negedge clk) begin
		if (stall_left != 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (hold_done != hold_asks) begin
			out_stall  <= 1'b1;
			stall_left <= LONG_HOLD - 1;
			hold_done  <= hold_done + 1;
		end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
			out_stall  <= 1'b1;
			stall_left <= $urandom_range(0, 8);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d reports outstanding", $time,
				pending_reports.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		tcc_cfg_t         s;
		logic [RAW_W-1:0] p, q;
		// hold reset, release it on a falling edge
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (SCRIPT[i])
			offer_frame(SCRIPT[i].f, SCRIPT[i].typed, SCRIPT[i].want);

		foreach (CORNER_SETTINGS[k]) begin
			apply_settings(CORNER_SETTINGS[k]);
			src_idle_on  = $urandom_range(0, 3) != 0;
			sink_idle_on = $urandom_range(0, 3) != 0;
			// starve the result side once so the block backs up into its input
			if (k == 2) hold_asks++;
			repeat (CORNER_ITEMS) offer_frame(next_frame(), 1'b0, '0);
		end

		for (int k = 0; k < RANDOM_PHASES; k++) begin
			// windows mostly ordered, now and then left in draw order
			p = RAW_W'($urandom_range(0, 4095));
			q = RAW_W'($urandom_range(0, 4095));
			s.x_min = ($urandom_range(0, 5) == 0 || p < q) ? p : q;
			s.x_max = (s.x_min == p) ? q : p;
			p = RAW_W'($urandom_range(0, 4095));
			q = RAW_W'($urandom_range(0, 4095));
			s.y_min = ($urandom_range(0, 5) == 0 || p < q) ? p : q;
			s.y_max = (s.y_min == p) ? q : p;
			// sizes mostly in the legal range, sometimes anything the field holds
			s.width  = RAW_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
				: $urandom_range(1, 2048));
			s.height = RAW_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
				: $urandom_range(1, 2048));
			apply_settings(s);
			src_idle_on  = $urandom_range(0, 3) != 0;
			sink_idle_on = $urandom_range(0, 3) != 0;
			if (k == 3) hold_asks++;
			repeat (RANDOM_ITEMS) offer_frame(next_frame(), 1'b0, '0);
		end

		// back-to-back traffic at the reset calibration, no idling either side
		apply_settings('{X_MIN_RST, X_MAX_RST, Y_MIN_RST, Y_MAX_RST, WIDTH_RST, HEIGHT_RST});
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		repeat (FINAL_ITEMS) offer_frame(next_frame(), 1'b0, '0);

		drain_reports();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (pending_reports.size() != 0) begin
			errors++;
			$display("%0t: %0d reports never arrived", $time, pending_reports.size());
		end

		$display("Sent %0d frames (%0d pressed) across %0d calibration settings, %0d reg writes",
			frames_sent, presses_sent, settings_used, reg_writes);
		$display("Checked %0d result beats field by field, %0d mismatches",
			reports_checked, errors);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire

/* sim.f */
+incdir+hdl
hdl/tcc_pkg.sv
hdl/tcc_regs.sv
hdl/tcc_ctrl.sv
hdl/tcc_dp.sv
hdl/touch_coordinate_conditioner_top.sv
bench/touch_coordinate_conditioner_top_tb.sv
